FILE: rtl/core/cnv_pkg.sv
`timescale 1ns / 1ps

package cnv_pkg;

  // Fixed widths of the beat fields.
  localparam int WORD_W = 16;
  localparam int OUT_W  = 15;
  localparam int IDX_W  = 7;
  localparam int TYPE_W = 2;

  // Kernel geometry and lane count.
  localparam int KW     = 3;
  localparam int TAPS   = KW * KW;
  localparam int MAX_CH = 8;

  // Output queue depth; ready is withheld once this many results are owed.
  localparam int Q_DEPTH = 8;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [TYPE_W-1:0] {
    REQ_WEIGHT = 2'd0,
    REQ_BIAS   = 2'd1,
    REQ_PIXEL  = 2'd2
  } req_type_e;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic [IDX_W-1:0]  coef_index;
    word_t             data_word;
  } cnv_req_t;

  typedef struct packed {
    logic [OUT_W-1:0] out_ch0;
    logic [OUT_W-1:0] out_ch1;
    logic [OUT_W-1:0] out_ch2;
    logic [OUT_W-1:0] out_ch3;
    logic [OUT_W-1:0] out_ch4;
    logic [OUT_W-1:0] out_ch5;
    logic [OUT_W-1:0] out_ch6;
    logic [OUT_W-1:0] out_ch7;
    logic             last_of_frame;
  } cnv_rsp_t;

  // Coefficient write, issued by the line buffer stage in beat order.
  typedef struct packed {
    logic             we_weight;
    logic             we_bias;
    logic [IDX_W-1:0] index;
    word_t            value;
  } coef_wr_t;

  // Qualifier of the window that the MAC pipeline consumes.
  typedef struct packed {
    logic vld;
    logic last;
  } win_ctl_t;

endpackage

FILE: rtl/core/cnv_ram.sv
`timescale 1ns / 1ps

module cnv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 28
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/cnv_linebuf.sv
`timescale 1ns / 1ps

module cnv_linebuf import cnv_pkg::*; #(
  parameter int IMG_WIDTH  = 28,
  parameter int IMG_HEIGHT = 28
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  cnv_req_t req_i,
  output logic     gives_result_o,
  output coef_wr_t coef_wr_o,
  output word_t    win_o [TAPS],
  output win_ctl_t win_ctl_o
);

  localparam int COL_W = $clog2(IMG_WIDTH);
  localparam int ROW_W = $clog2(IMG_HEIGHT);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(IMG_WIDTH - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(IMG_HEIGHT - 1);
  localparam logic [COL_W-1:0] COL_MIN  = COL_W'(KW - 1);
  localparam logic [ROW_W-1:0] ROW_MIN  = ROW_W'(KW - 1);

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             pix_acc;
  logic             pos_res;
  logic             pos_last;

  logic              s1_vld_q;
  logic [TYPE_W-1:0] s1_kind_q;
  logic [IDX_W-1:0]  s1_idx_q;
  word_t             s1_word_q;
  logic [COL_W-1:0]  s1_col_q;
  logic              s1_res_q;
  logic              s1_last_q;
  logic              s1_pix;

  logic [2*WORD_W-1:0] ram_rdata;
  word_t               line_older;
  word_t               line_newer;

  word_t    win_q [TAPS];
  win_ctl_t win_ctl_q;

  assign pix_acc        = accept_i && (req_i.req_type == REQ_PIXEL);
  assign pos_res        = (row_q >= ROW_MIN) && (col_q >= COL_MIN);
  assign pos_last       = (row_q == ROW_LAST) && (col_q == COL_LAST);
  assign gives_result_o = pix_acc && pos_res;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (pix_acc) begin
      if (col_q == COL_LAST) begin
        col_d = '0;
        row_d = (row_q == ROW_LAST) ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      s1_vld_q <= 1'b0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      s1_vld_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_kind_q <= req_i.req_type;
      s1_idx_q  <= req_i.coef_index;
      s1_word_q <= req_i.data_word;
      s1_col_q  <= col_q;
      s1_res_q  <= pos_res;
      s1_last_q <= pos_last;
    end
  end

  assign s1_pix = s1_vld_q && (s1_kind_q == REQ_PIXEL);

  // Each entry holds the two previous rows of one column. It is read when
  // the pixel is taken and written back in the following cycle; the next pixel
  // always reads a different column, so the two never meet.
  cnv_ram #(
    .WIDTH(2 * WORD_W),
    .DEPTH(IMG_WIDTH)
  ) u_lines (
    .clk_i  (clk_i),
    .we_i   (s1_pix),
    .waddr_i(s1_col_q),
    .wdata_i({ram_rdata[WORD_W-1:0], s1_word_q}),
    .re_i   (pix_acc),
    .raddr_i(col_q),
    .rdata_o(ram_rdata)
  );

  assign line_older = ram_rdata[2*WORD_W-1:WORD_W];
  assign line_newer = ram_rdata[WORD_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < TAPS; t++) begin
        win_q[t] <= '0;
      end
      win_ctl_q <= '0;
    end else begin
      if (s1_pix) begin
        for (int r = 0; r < KW; r++) begin
          for (int c = 0; c < KW - 1; c++) begin
            win_q[r*KW+c] <= win_q[r*KW+c+1];
          end
        end
        win_q[KW-1]     <= line_older;
        win_q[2*KW-1]   <= line_newer;
        win_q[KW*KW-1]  <= s1_word_q;
      end
      win_ctl_q.vld  <= s1_pix && s1_res_q;
      win_ctl_q.last <= s1_last_q;
    end
  end

  assign coef_wr_o.we_weight = s1_vld_q && (s1_kind_q == REQ_WEIGHT);
  assign coef_wr_o.we_bias   = s1_vld_q && (s1_kind_q == REQ_BIAS);
  assign coef_wr_o.index     = s1_idx_q;
  assign coef_wr_o.value     = s1_word_q;

  assign win_o     = win_q;
  assign win_ctl_o = win_ctl_q;

endmodule

FILE: rtl/core/cnv_mac.sv
`timescale 1ns / 1ps

module cnv_mac import cnv_pkg::*; #(
  parameter int OUT_CHANNELS = 8,
  parameter int DATA_WIDTH   = 16,
  parameter int FRAC_BITS    = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  coef_wr_t coef_wr_i,
  input  word_t    win_i [TAPS],
  input  win_ctl_t win_ctl_i,
  output logic     push_o,
  output cnv_rsp_t rsp_o
);

  localparam int PROD_W = 2 * WORD_W;
  localparam int BSH_W  = WORD_W + FRAC_BITS;
  localparam int ACC_W  = ((PROD_W > BSH_W) ? PROD_W : BSH_W) + 4;
  localparam logic [ACC_W-1:0] SAT_MAX = ACC_W'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);

  logic vld_c_q, vld_d_q, vld_e_q;
  logic last_c_q, last_d_q, last_e_q;
  logic [OUT_W-1:0] ch_res [MAX_CH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c_q <= 1'b0;
      vld_d_q <= 1'b0;
      vld_e_q <= 1'b0;
    end else begin
      vld_c_q <= win_ctl_i.vld;
      vld_d_q <= vld_c_q;
      vld_e_q <= vld_d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    last_c_q <= win_ctl_i.last;
    last_d_q <= last_c_q;
    last_e_q <= last_d_q;
  end

  for (genvar ch = 0; ch < MAX_CH; ch++) begin : g_lane
    if (ch < OUT_CHANNELS) begin : g_on
      word_t                    w_q [TAPS];
      word_t                    b_q;
      word_t                    b_c_q;
      logic signed [PROD_W-1:0] p_q [TAPS];
      logic signed [ACC_W-1:0]  sa_q, sb_q, sc_q, tot_q;
      logic [ACC_W-1:0]         shr;
      logic [ACC_W-1:0]         sat;

      // Coefficients are written in beat order relative to the pixels, so
      // the product stage below always sees the set that was current when
      // its pixel arrived.
      always_ff @(posedge clk_i) begin
        for (int k = 0; k < TAPS; k++) begin
          if (coef_wr_i.we_weight && (coef_wr_i.index == IDX_W'(ch * TAPS + k))) begin
            w_q[k] <= coef_wr_i.value;
          end
        end
        if (coef_wr_i.we_bias && (coef_wr_i.index == IDX_W'(ch))) begin
          b_q <= coef_wr_i.value;
        end
      end

      always_ff @(posedge clk_i) begin
        for (int k = 0; k < TAPS; k++) begin
          p_q[k] <= w_q[k] * win_i[k];
        end
        b_c_q <= b_q;
        sa_q  <= ACC_W'(p_q[0]) + ACC_W'(p_q[1]) + ACC_W'(p_q[2]);
        sb_q  <= ACC_W'(p_q[3]) + ACC_W'(p_q[4]) + ACC_W'(p_q[5]);
        sc_q  <= ACC_W'(p_q[6]) + ACC_W'(p_q[7]) + ACC_W'(p_q[8])
               + (ACC_W'(b_c_q) <<< FRAC_BITS);
        tot_q <= sa_q + sb_q + sc_q;
      end

      always_comb begin
        shr = $unsigned(tot_q) >> FRAC_BITS;
        if (tot_q[ACC_W-1]) begin
          sat = '0;
        end else if (shr > SAT_MAX) begin
          sat = SAT_MAX;
        end else begin
          sat = shr;
        end
      end

      assign ch_res[ch] = sat[OUT_W-1:0];
    end else begin : g_off
      assign ch_res[ch] = '0;
    end
  end

  assign push_o = vld_e_q;
  assign rsp_o  = '{
    out_ch0:       ch_res[0],
    out_ch1:       ch_res[1],
    out_ch2:       ch_res[2],
    out_ch3:       ch_res[3],
    out_ch4:       ch_res[4],
    out_ch5:       ch_res[5],
    out_ch6:       ch_res[6],
    out_ch7:       ch_res[7],
    last_of_frame: last_e_q
  };

endmodule

FILE: rtl/core/cnv_ofifo.sv
`timescale 1ns / 1ps

module cnv_ofifo import cnv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  cnv_rsp_t data_i,
  output logic     valid_o,
  input  logic     ready_i,
  output cnv_rsp_t data_o
);

  cnv_rsp_t           mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_q, rd_q;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  logic               pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_q];

  // The credit count at the input keeps pushes from ever overrunning.
  always_comb begin
    cnt_d = cnt_q;
    unique case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + Q_CNT_W'(1);
      2'b01:   cnt_d = cnt_q - Q_CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= wr_q + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_q <= rd_q + Q_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/core/conv3x3_relu_8ch_linebuf.sv
`timescale 1ns / 1ps

// 3x3 valid convolution with ReLU over a raster pixel stream, eight output
// channels per window. One beat is taken every cycle while ready is high,
// pixel or coefficient load alike; a pixel whose window is complete (row
// and column at least 2) gives its result through a six-stage path:
// line memory read, window shift, nine products per channel, two adder
// levels, then ReLU, truncation and saturation into an 8-entry output
// queue. Input ready drops only while 8 results are owed downstream, so the
// rate stays at one beat per cycle as long as results are taken. The two
// previous rows live in one IMG_WIDTH-deep memory that is read and written
// back at one column per pixel; it needs no clearing after reset. Weight
// and bias loads take effect for every pixel beat that follows them.
module conv3x3_relu_8ch_linebuf import cnv_pkg::*; #(
  parameter int IMG_WIDTH    = 28,
  parameter int IMG_HEIGHT   = 28,
  parameter int OUT_CHANNELS = 8,
  parameter int DATA_WIDTH   = 16,
  parameter int FRAC_BITS    = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  cnv_req_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output cnv_rsp_t out_data_o
);

  logic               accept;
  logic               gives_result;
  logic               out_pop;
  logic [Q_CNT_W-1:0] owed_q, owed_d;
  coef_wr_t           coef_wr;
  word_t              win [TAPS];
  win_ctl_t           win_ctl;
  logic               push;
  cnv_rsp_t           rsp;

  assign accept     = in_valid_i && in_ready_o;
  assign out_pop    = out_valid_o && out_ready_i;
  assign in_ready_o = (owed_q < Q_CNT_W'(Q_DEPTH));

  // Results in flight plus results queued; bounds the queue occupancy.
  always_comb begin
    owed_d = owed_q;
    unique case ({gives_result, out_pop})
      2'b10:   owed_d = owed_q + Q_CNT_W'(1);
      2'b01:   owed_d = owed_q - Q_CNT_W'(1);
      default: owed_d = owed_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owed_q <= '0;
    end else begin
      owed_q <= owed_d;
    end
  end

  cnv_linebuf #(
    .IMG_WIDTH (IMG_WIDTH),
    .IMG_HEIGHT(IMG_HEIGHT)
  ) u_linebuf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .req_i         (in_data_i),
    .gives_result_o(gives_result),
    .coef_wr_o     (coef_wr),
    .win_o         (win),
    .win_ctl_o     (win_ctl)
  );

  cnv_mac #(
    .OUT_CHANNELS(OUT_CHANNELS),
    .DATA_WIDTH  (DATA_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .coef_wr_i(coef_wr),
    .win_i    (win),
    .win_ctl_i(win_ctl),
    .push_o   (push),
    .rsp_o    (rsp)
  );

  cnv_ofifo u_ofifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (rsp),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .data_o (out_data_o)
  );

endmodule

FILE: rtl/core/cnv_chk.sv
`timescale 1ns / 1ps

module cnv_chk import cnv_pkg::*; #(
  parameter int OUT_CHANNELS = 8
) (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input cnv_req_t in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input cnv_rsp_t out_data_o
);

  logic [OUT_W-1:0] ch [MAX_CH];

  assign ch[0] = out_data_o.out_ch0;
  assign ch[1] = out_data_o.out_ch1;
  assign ch[2] = out_data_o.out_ch2;
  assign ch[3] = out_data_o.out_ch3;
  assign ch[4] = out_data_o.out_ch4;
  assign ch[5] = out_data_o.out_ch5;
  assign ch[6] = out_data_o.out_ch6;
  assign ch[7] = out_data_o.out_ch7;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result beat changed while stalled");

  // With the queue empty, a new result appears exactly at the pipeline depth
  // after the pixel that produced it.
  a_out_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |->
      $past(in_valid_i && in_ready_o && (in_data_i.req_type == REQ_PIXEL), 6))
    else $error("result beat without a pixel beat at pipeline depth");

  for (genvar c = 0; c < MAX_CH; c++) begin : g_unused
    if (c >= OUT_CHANNELS) begin : g_chk
      a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
        out_valid_o |-> (ch[c] == '0))
        else $error("unused channel carries a nonzero value");
    end
  end

endmodule

bind conv3x3_relu_8ch_linebuf cnv_chk #(
  .OUT_CHANNELS(OUT_CHANNELS)
) u_cnv_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
